[hw/rtl/mvec_pkg.sv]
// ----------------------------------------------------------------------------
// mvec_pkg
// Shared types and constants for the mesh vertex extremum classifier.
// ----------------------------------------------------------------------------
package mvec_pkg;

  // field widths fixed by the interface
  localparam int VIDX_W     = 8;
  localparam int SAMPLE_W   = 32;
  localparam int CNT_W      = 9;
  localparam int VCOUNT_W   = 9;
  localparam int FRAC_W     = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int THR_W      = CNT_W + FRAC_W;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 17;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_VERTEX_COUNT      = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_EXTREMUM_FRACTION = 1'd1;

  // reset values of the configuration registers
  localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RST      = 9'd256;
  localparam logic [FRAC_W-1:0]   EXTREMUM_FRACTION_RST = 17'd65536;

  typedef enum logic [1:0] {
    ACT_CLEAR    = 2'd0,
    ACT_FACE     = 2'd1,
    ACT_VALUE    = 2'd2,
    ACT_CLASSIFY = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_F_RD,
    ST_F_WR,
    ST_C_RD,
    ST_C_SELF,
    ST_WALK,
    ST_MUL,
    ST_RESULT
  } state_t;

  // neighbor accumulator control
  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctl_t;

endpackage

[hw/rtl/mesh_vertex_extremum_classifier.sv]
// ----------------------------------------------------------------------------
// mesh_vertex_extremum_classifier
// Builds a symmetric vertex adjacency bitmap from triangle faces, stores one
// signed value per vertex and classifies a vertex as local minimum / maximum
// from the values of its neighbors.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata / data                     tuser
//  in_      slave      a, b, c, sample_value (56 bits)  action
//  out_     master     min, max, neighbor_count         status
//  cfg_     write      vertex_count, extremum_fraction  -
//
// One item at a time; in_tready is high only while the sequencer is idle.
// A classify walks the effective vertex count n, one neighbor value read per
// cycle; a face load is a read-modify-write of three rows; value loads and
// rejected items go straight to the result state, a clear after a clearing
// pass. After reset a clearing pass runs first.
// A stalled output holds only the sequencer's result state.
// ----------------------------------------------------------------------------
module mesh_vertex_extremum_classifier #(
  parameter int MAX_VERTICES = 256,
  parameter int VALUE_BITS   = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: vertex_a[7:0], vertex_b[15:8], vertex_c[23:16], sample_value[55:24]
  input  logic [55:0]                       in_tdata,
  // tuser: action[1:0]
  input  logic [1:0]                        in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: is_local_minimum[0], is_local_maximum[1], neighbor_count[10:2], zero
  output logic [15:0]                       out_tdata,
  // tuser: status[0]
  output logic [0:0]                        out_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [mvec_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [mvec_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  logic [mvec_pkg::VCOUNT_W-1:0] vcount_r;
  logic [mvec_pkg::FRAC_W-1:0]   frac_r;
  logic [CW-1:0]                 n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= mvec_pkg::VERTEX_COUNT_RST;
      frac_r   <= mvec_pkg::EXTREMUM_FRACTION_RST;
    end else if (cfg_we) begin
      if (cfg_addr == mvec_pkg::REG_VERTEX_COUNT) begin
        vcount_r <= cfg_wdata[mvec_pkg::VCOUNT_W-1:0];
      end else begin
        frac_r <= cfg_wdata[mvec_pkg::FRAC_W-1:0];
      end
    end
  end

  assign n_eff = (32'(vcount_r) < MAX_VERTICES) ? CW'(vcount_r) : CW'(MAX_VERTICES);

  // --------------------------------------------------------------------------
  // input unpacking
  // --------------------------------------------------------------------------
  mvec_pkg::action_t                    in_action;
  logic [mvec_pkg::VIDX_W-1:0]          in_a, in_b, in_c;
  logic signed [mvec_pkg::SAMPLE_W-1:0] in_sample;
  logic                                 in_xfer;
  logic                                 a_bad, b_bad, c_bad, in_bad;

  assign in_action = mvec_pkg::action_t'(in_tuser);
  assign in_a      = in_tdata[7:0];
  assign in_b      = in_tdata[15:8];
  assign in_c      = in_tdata[23:16];
  assign in_sample = in_tdata[55:24];
  assign in_xfer   = in_tvalid & in_tready;

  assign a_bad = 32'(in_a) >= 32'(n_eff);
  assign b_bad = 32'(in_b) >= 32'(n_eff);
  assign c_bad = 32'(in_c) >= 32'(n_eff);

  always_comb begin
    case (in_action)
      mvec_pkg::ACT_CLEAR: in_bad = 1'b0;
      mvec_pkg::ACT_FACE:  in_bad = a_bad | b_bad | c_bad;
      default:             in_bad = a_bad;
    endcase
  end

  // --------------------------------------------------------------------------
  // state
  // --------------------------------------------------------------------------
  mvec_pkg::state_t state_r, state_nxt;
  logic                              boot_r, boot_nxt;
  logic [AW-1:0]                     clr_cnt_r, clr_cnt_nxt;
  logic [1:0]                        k_r, k_nxt;
  logic [CW-1:0]                     j_r, j_nxt;
  logic                              pend_r, pend_nxt;
  mvec_pkg::action_t                 op_r, op_nxt;
  logic                              bad_r, bad_nxt;
  logic [mvec_pkg::VIDX_W-1:0]       a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [MAX_VERTICES-1:0]           row_sr_r, row_sr_nxt;
  logic signed [VALUE_BITS-1:0]      self_r, self_nxt;
  logic [mvec_pkg::THR_W-1:0]        thr_r, thr_nxt;

  logic                              clr_last, walk_issue, out_free;

  assign clr_last   = clr_cnt_r == AW'(MAX_VERTICES - 1);
  assign walk_issue = j_r < n_eff;
  assign out_free   = ~out_tvalid | out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mvec_pkg::ST_CLR: begin
        if (clr_last) begin
          state_nxt = boot_r ? mvec_pkg::ST_IDLE : mvec_pkg::ST_RESULT;
        end
      end
      mvec_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in_action == mvec_pkg::ACT_CLEAR) begin
            state_nxt = mvec_pkg::ST_CLR;
          end else if (in_bad || in_action == mvec_pkg::ACT_VALUE) begin
            state_nxt = mvec_pkg::ST_RESULT;
          end else if (in_action == mvec_pkg::ACT_FACE) begin
            state_nxt = mvec_pkg::ST_F_RD;
          end else begin
            state_nxt = mvec_pkg::ST_C_RD;
          end
        end
      end
      mvec_pkg::ST_F_RD:   state_nxt = mvec_pkg::ST_F_WR;
      mvec_pkg::ST_F_WR:   state_nxt = (k_r == 2'd2) ? mvec_pkg::ST_RESULT : mvec_pkg::ST_F_RD;
      mvec_pkg::ST_C_RD:   state_nxt = mvec_pkg::ST_C_SELF;
      mvec_pkg::ST_C_SELF: state_nxt = mvec_pkg::ST_WALK;
      mvec_pkg::ST_WALK: begin
        if (!walk_issue) begin
          state_nxt = mvec_pkg::ST_MUL;
        end
      end
      mvec_pkg::ST_MUL:    state_nxt = mvec_pkg::ST_RESULT;
      mvec_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = mvec_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = mvec_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath control
  // --------------------------------------------------------------------------
  logic                    adj_we;
  logic [AW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    val_we;
  logic [AW-1:0]           val_raddr;
  logic signed [VALUE_BITS-1:0] val_wdata, val_rdata;
  mvec_pkg::acc_ctl_t      acc_ctl;
  logic [mvec_pkg::CNT_W-1:0] deg, hi, lo;

  logic [mvec_pkg::VIDX_W-1:0] row_sel, oth_x, oth_y;
  logic [MAX_VERTICES-1:0]     face_mask;

  always_comb begin
    case (k_r)
      2'd0:    begin row_sel = a_r; oth_x = b_r; oth_y = c_r; end
      2'd1:    begin row_sel = b_r; oth_x = a_r; oth_y = c_r; end
      default: begin row_sel = c_r; oth_x = a_r; oth_y = b_r; end
    endcase
  end

  assign face_mask = (MAX_VERTICES'(1) << AW'(oth_x)) | (MAX_VERTICES'(1) << AW'(oth_y));

  assign val_we    = in_xfer & (in_action == mvec_pkg::ACT_VALUE) & ~a_bad;
  assign val_wdata = VALUE_BITS'(in_sample);

  always_comb begin
    in_tready   = 1'b0;
    boot_nxt    = boot_r;
    clr_cnt_nxt = clr_cnt_r;
    k_nxt       = k_r;
    j_nxt       = j_r;
    pend_nxt    = 1'b0;
    op_nxt      = op_r;
    bad_nxt     = bad_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    c_nxt       = c_r;
    row_sr_nxt  = row_sr_r;
    self_nxt    = self_r;
    thr_nxt     = thr_r;
    adj_we      = 1'b0;
    adj_waddr   = AW'(row_sel);
    adj_wdata   = adj_rdata | face_mask;
    adj_raddr   = AW'(row_sel);
    val_raddr   = j_r[AW-1:0];
    acc_ctl     = '0;
    unique case (state_r)
      mvec_pkg::ST_CLR: begin
        adj_we      = 1'b1;
        adj_waddr   = clr_cnt_r;
        adj_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_last) begin
          boot_nxt = 1'b0;
        end
      end
      mvec_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_xfer) begin
          op_nxt      = in_action;
          bad_nxt     = in_bad;
          a_nxt       = in_a;
          b_nxt       = in_b;
          c_nxt       = in_c;
          k_nxt       = '0;
          clr_cnt_nxt = '0;
          acc_ctl.clear = 1'b1;
        end
      end
      mvec_pkg::ST_F_RD: begin
      end
      mvec_pkg::ST_F_WR: begin
        adj_we = 1'b1;
        k_nxt  = k_r + 1'b1;
      end
      mvec_pkg::ST_C_RD: begin
        adj_raddr = AW'(a_r);
        val_raddr = AW'(a_r);
      end
      mvec_pkg::ST_C_SELF: begin
        self_nxt   = val_rdata;
        row_sr_nxt = adj_rdata;
        j_nxt      = '0;
      end
      mvec_pkg::ST_WALK: begin
        // issue read for neighbor j, count the one read last cycle
        acc_ctl.step = pend_r;
        if (walk_issue) begin
          pend_nxt   = row_sr_r[0];
          row_sr_nxt = row_sr_r >> 1;
          j_nxt      = j_r + 1'b1;
        end
      end
      mvec_pkg::ST_MUL: begin
        thr_nxt = mvec_pkg::THR_W'(deg) * mvec_pkg::THR_W'(frac_r);
      end
      mvec_pkg::ST_RESULT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mvec_pkg::ST_CLR;
      boot_r    <= 1'b1;
      clr_cnt_r <= '0;
      k_r       <= '0;
      j_r       <= '0;
      pend_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      boot_r    <= boot_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      k_r       <= k_nxt;
      j_r       <= j_nxt;
      pend_r    <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    bad_r    <= bad_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    c_r      <= c_nxt;
    row_sr_r <= row_sr_nxt;
    self_r   <= self_nxt;
    thr_r    <= thr_nxt;
  end

  // --------------------------------------------------------------------------
  // storage and shared compare unit
  // --------------------------------------------------------------------------
  mvec_ram #(
    .WIDTH (MAX_VERTICES),
    .DEPTH (MAX_VERTICES)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  mvec_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_VERTICES)
  ) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (AW'(in_a)),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  mvec_acc #(
    .VALUE_BITS (VALUE_BITS)
  ) u_acc (
    .clk        (clk),
    .ctl        (acc_ctl),
    .nbr_value  (val_rdata),
    .self_value (self_r),
    .deg        (deg),
    .hi         (hi),
    .lo         (lo)
  );

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_status_r, out_min_r, out_max_r;
  logic [mvec_pkg::CNT_W-1:0] out_cnt_r;
  logic                       out_load, cls_ok;
  logic [mvec_pkg::THR_W-1:0] hi_scaled, lo_scaled;

  assign out_load      = (state_r == mvec_pkg::ST_RESULT) & out_free;
  assign out_valid_nxt = out_load | (out_valid_r & ~out_tready);
  assign cls_ok        = (op_r == mvec_pkg::ACT_CLASSIFY) & ~bad_r;
  assign hi_scaled     = mvec_pkg::THR_W'(hi) << mvec_pkg::FRAC_SHIFT;
  assign lo_scaled     = mvec_pkg::THR_W'(lo) << mvec_pkg::FRAC_SHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= bad_r;
      out_min_r    <= cls_ok & (hi_scaled >= thr_r);
      out_max_r    <= cls_ok & (lo_scaled >= thr_r);
      out_cnt_r    <= cls_ok ? deg : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_max_r, out_min_r};
  assign out_tuser  = out_status_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted on consecutive cycles");

  a_flags_need_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[0] || out_tdata[1] || out_tdata[10:2] != 9'd0)
      |-> !out_tuser[0])
    else $error("classification flags on a failed item");

  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> 32'(out_tdata[10:2]) <= 32'(n_eff))
    else $error("neighbor count above vertex count");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mvec_pkg::ST_WALK |-> j_r <= n_eff)
    else $error("walk index past vertex count");

endmodule

[hw/rtl/mvec_ram.sv]
// ----------------------------------------------------------------------------
// mvec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mvec_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/mvec_acc.sv]
// ----------------------------------------------------------------------------
// mvec_acc
// Shared neighbor compare unit: one signed value compare per cycle, with
// running counts of neighbors, higher neighbors and lower neighbors.
// ----------------------------------------------------------------------------
module mvec_acc #(
  parameter int VALUE_BITS = 32
) (
  input  logic                          clk,
  input  mvec_pkg::acc_ctl_t            ctl,
  input  logic signed [VALUE_BITS-1:0]  nbr_value,
  input  logic signed [VALUE_BITS-1:0]  self_value,
  output logic [mvec_pkg::CNT_W-1:0]    deg,
  output logic [mvec_pkg::CNT_W-1:0]    hi,
  output logic [mvec_pkg::CNT_W-1:0]    lo
);

  logic [mvec_pkg::CNT_W-1:0] deg_r, deg_nxt;
  logic [mvec_pkg::CNT_W-1:0] hi_r, hi_nxt;
  logic [mvec_pkg::CNT_W-1:0] lo_r, lo_nxt;
  logic                       gt, lt;

  assign gt = nbr_value > self_value;
  assign lt = nbr_value < self_value;

  always_comb begin
    deg_nxt = deg_r;
    hi_nxt  = hi_r;
    lo_nxt  = lo_r;
    if (ctl.clear) begin
      deg_nxt = '0;
      hi_nxt  = '0;
      lo_nxt  = '0;
    end else if (ctl.step) begin
      deg_nxt = deg_r + 1'b1;
      if (gt) begin
        hi_nxt = hi_r + 1'b1;
      end
      if (lt) begin
        lo_nxt = lo_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    deg_r <= deg_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
  end

  assign deg = deg_r;
  assign hi  = hi_r;
  assign lo  = lo_r;

endmodule
